### src/lfs_pkg.sv
`default_nettype none
package lfs_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CFG_W       = 12;
  localparam int SPEED_W     = 7;
  localparam int OUT_W       = 16;
  localparam int NUM_REGS    = 7;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // register indexes
  localparam logic [2:0] REG_CRUISE = 3'd0;
  localparam logic [2:0] REG_BASE   = 3'd1;
  localparam logic [2:0] REG_GAIN   = 3'd2;
  localparam logic [2:0] REG_LEAVE  = 3'd3;
  localparam logic [2:0] REG_RETURN = 3'd4;
  localparam logic [2:0] REG_IND    = 3'd5;
  localparam logic [2:0] REG_DARK   = 3'd6;

  // mode codes as seen on the result port
  localparam logic [2:0] CODE_IDLE     = 3'd0;
  localparam logic [2:0] CODE_STRAIGHT = 3'd1;
  localparam logic [2:0] CODE_TURNING  = 3'd2;
  localparam logic [2:0] CODE_SHARP    = 3'd3;
  localparam logic [2:0] CODE_STOPPED  = 3'd4;

  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_STRAIGHT = 5'b00010,
    MODE_TURNING  = 5'b00100,
    MODE_SHARP    = 5'b01000,
    MODE_STOPPED  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] base_speed;
    logic [CFG_W-1:0]   steer_gain;
    logic [CFG_W-1:0]   leave_band;
    logic [CFG_W-1:0]   return_band;
    logic [CFG_W-1:0]   indicator_band;
    logic [CFG_W-1:0]   dark_level;
  } cfg_t;

  typedef struct packed {
    logic                   start_jack;
    logic                   end_switch;
    logic [SAMPLE_BITS-1:0] right_inner;
    logic [SAMPLE_BITS-1:0] right_outer;
    logic [SAMPLE_BITS-1:0] left_inner;
    logic [SAMPLE_BITS-1:0] left_outer;
  } sample_t;

  typedef struct packed {
    mode_e                   mode;
    logic                    led;
    logic signed [OUT_W-1:0] left_speed;
    logic signed [OUT_W-1:0] right_speed;
  } result_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    unique case (m)
      MODE_IDLE:     c = CODE_IDLE;
      MODE_STRAIGHT: c = CODE_STRAIGHT;
      MODE_TURNING:  c = CODE_TURNING;
      MODE_SHARP:    c = CODE_SHARP;
      default:       c = CODE_STOPPED;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### src/line_follower_steering_fsm_core.sv
// A word accepted into the input register moves to the result register when
//   that register is empty or being drained. Throughput: one word per cycle
//   while out_ready_i is high, set by the single registered steering stage
//   (one 13x13 multiply plus compares between the input and result registers).
// Reset (rst_ni low, asynchronous): mode idle, indicator off, pipeline empty,
//   configuration registers back to their defaults.
`default_nettype none
module line_follower_steering_fsm_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lfs_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [lfs_pkg::DATA_W-1:0]          pwdata,
  output logic      [lfs_pkg::DATA_W-1:0]          prdata,
  output logic                                     pready,
  // sample channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                start_jack_i,
  input  wire logic                                end_switch_i,
  input  wire logic [lfs_pkg::SAMPLE_BITS-1:0]     right_inner_i,
  input  wire logic [lfs_pkg::SAMPLE_BITS-1:0]     right_outer_i,
  input  wire logic [lfs_pkg::SAMPLE_BITS-1:0]     left_inner_i,
  input  wire logic [lfs_pkg::SAMPLE_BITS-1:0]     left_outer_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [lfs_pkg::OUT_W-1:0]         left_speed_o,
  output logic signed [lfs_pkg::OUT_W-1:0]         right_speed_o,
  output logic                                     indicator_o,
  output logic [2:0]                               mode_o
);

  lfs_pkg::cfg_t    cfg;
  lfs_pkg::sample_t smp_q;
  lfs_pkg::result_t res;
  lfs_pkg::mode_e   mode_q;
  logic             led_q;
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             advance;

  logic signed [lfs_pkg::OUT_W-1:0] left_q, right_q;
  logic                             ind_q;
  logic [2:0]                       code_q;

  lfs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // result stage moves when its register is empty or being drained
  assign advance    = !out_valid_q || out_ready_i;
  // input stage takes a word whenever its slot frees up this cycle
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q.start_jack  <= start_jack_i;
      smp_q.end_switch  <= end_switch_i;
      smp_q.right_inner <= right_inner_i;
      smp_q.right_outer <= right_outer_i;
      smp_q.left_inner  <= left_inner_i;
      smp_q.left_outer  <= left_outer_i;
    end
  end

  // mode transition and motor commands for the word in the input register
  lfs_steer u_steer (
    .smp_i  (smp_q),
    .cfg_i  (cfg),
    .mode_i (mode_q),
    .led_i  (led_q),
    .res_o  (res)
  );

  // state advances exactly once per word, when it moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= lfs_pkg::MODE_IDLE;
      led_q       <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        mode_q <= res.mode;
        led_q  <= res.led;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      left_q  <= res.left_speed;
      right_q <= res.right_speed;
      ind_q   <= res.led;
      code_q  <= lfs_pkg::mode_code(res.mode);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign indicator_o   = ind_q;
  assign mode_o        = code_q;

endmodule
`default_nettype wire

### src/lfs_cfg_regs.sv
`default_nettype none
module lfs_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lfs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lfs_pkg::DATA_W-1:0] pwdata,
  output logic      [lfs_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output lfs_pkg::cfg_t                   cfg_o
);

  lfs_pkg::cfg_t cfg_q;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed   <= lfs_pkg::SPEED_W'(35);
      cfg_q.base_speed     <= lfs_pkg::SPEED_W'(30);
      cfg_q.steer_gain     <= lfs_pkg::CFG_W'(264);
      cfg_q.leave_band     <= lfs_pkg::CFG_W'(62);
      cfg_q.return_band    <= lfs_pkg::CFG_W'(25);
      cfg_q.indicator_band <= lfs_pkg::CFG_W'(12);
      cfg_q.dark_level     <= lfs_pkg::CFG_W'(1241);
    end else if (wr_en) begin
      unique case (idx)
        lfs_pkg::REG_CRUISE: cfg_q.cruise_speed   <= pwdata[lfs_pkg::SPEED_W-1:0];
        lfs_pkg::REG_BASE:   cfg_q.base_speed     <= pwdata[lfs_pkg::SPEED_W-1:0];
        lfs_pkg::REG_GAIN:   cfg_q.steer_gain     <= pwdata[lfs_pkg::CFG_W-1:0];
        lfs_pkg::REG_LEAVE:  cfg_q.leave_band     <= pwdata[lfs_pkg::CFG_W-1:0];
        lfs_pkg::REG_RETURN: cfg_q.return_band    <= pwdata[lfs_pkg::CFG_W-1:0];
        lfs_pkg::REG_IND:    cfg_q.indicator_band <= pwdata[lfs_pkg::CFG_W-1:0];
        lfs_pkg::REG_DARK:   cfg_q.dark_level     <= pwdata[lfs_pkg::CFG_W-1:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      lfs_pkg::REG_CRUISE: prdata = lfs_pkg::DATA_W'(cfg_q.cruise_speed);
      lfs_pkg::REG_BASE:   prdata = lfs_pkg::DATA_W'(cfg_q.base_speed);
      lfs_pkg::REG_GAIN:   prdata = lfs_pkg::DATA_W'(cfg_q.steer_gain);
      lfs_pkg::REG_LEAVE:  prdata = lfs_pkg::DATA_W'(cfg_q.leave_band);
      lfs_pkg::REG_RETURN: prdata = lfs_pkg::DATA_W'(cfg_q.return_band);
      lfs_pkg::REG_IND:    prdata = lfs_pkg::DATA_W'(cfg_q.indicator_band);
      lfs_pkg::REG_DARK:   prdata = lfs_pkg::DATA_W'(cfg_q.dark_level);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/lfs_steer.sv
`default_nettype none
module lfs_steer (
  input  wire lfs_pkg::sample_t smp_i,
  input  wire lfs_pkg::cfg_t    cfg_i,
  input  wire lfs_pkg::mode_e   mode_i,
  input  wire logic             led_i,
  output lfs_pkg::result_t      res_o
);

  localparam int SB     = lfs_pkg::SAMPLE_BITS;
  localparam int ERR_W  = SB + 1;
  localparam int CMP_W  = (ERR_W > lfs_pkg::CFG_W) ? ERR_W : lfs_pkg::CFG_W;
  localparam int PROD_W = lfs_pkg::CFG_W + 1 + ERR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SCL_W  = SUM_W + 3;
  localparam int OW     = lfs_pkg::OUT_W;

  localparam logic signed [SCL_W-1:0] SAT_MAX = SCL_W'((2 ** (OW - 1)) - 1);
  localparam logic signed [SCL_W-1:0] SAT_MIN = SCL_W'(-(2 ** (OW - 1)));

  logic signed [ERR_W-1:0]  err;
  logic        [ERR_W-1:0]  mag;
  logic        [CMP_W-1:0]  mag_x;
  logic                     rdark, ldark;
  logic                     ge_leave, le_leave, le_return, le_ind;
  lfs_pkg::mode_e           cur, nxt;
  logic signed [PROD_W-1:0] prod, steer;
  logic signed [SUM_W-1:0]  ctr, ls, rs;
  logic signed [SCL_W-1:0]  ls_x, rs_x, ls_f, rs_f;
  logic signed [OW-1:0]     cruise;

  function automatic logic signed [OW-1:0] sat(logic signed [SCL_W-1:0] v);
    logic signed [SCL_W-1:0] c;
    c = v;
    if (v > SAT_MAX) c = SAT_MAX;
    if (v < SAT_MIN) c = SAT_MIN;
    return c[OW-1:0];
  endfunction

  assign err   = $signed({1'b0, smp_i.left_inner}) - $signed({1'b0, smp_i.right_inner});
  assign mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign mag_x = CMP_W'(mag);

  assign rdark     = CMP_W'(smp_i.right_outer) < CMP_W'(cfg_i.dark_level);
  assign ldark     = CMP_W'(smp_i.left_outer)  < CMP_W'(cfg_i.dark_level);
  assign ge_leave  = mag_x >= CMP_W'(cfg_i.leave_band);
  assign le_leave  = mag_x <= CMP_W'(cfg_i.leave_band);
  assign le_return = mag_x <= CMP_W'(cfg_i.return_band);
  assign le_ind    = mag_x <= CMP_W'(cfg_i.indicator_band);

  // end switch low wins before anything else and forces the stopped mode
  assign cur = smp_i.end_switch ? mode_i : lfs_pkg::MODE_STOPPED;

  always_comb begin
    nxt = cur;
    unique case (cur)
      lfs_pkg::MODE_IDLE: begin
        if (smp_i.start_jack) nxt = lfs_pkg::MODE_STRAIGHT;
      end
      lfs_pkg::MODE_STRAIGHT: begin
        if (ge_leave) nxt = lfs_pkg::MODE_TURNING;
      end
      lfs_pkg::MODE_TURNING: begin
        priority if (le_leave)      nxt = lfs_pkg::MODE_STRAIGHT;
        else if (rdark || ldark)    nxt = lfs_pkg::MODE_SHARP;
        else                        nxt = lfs_pkg::MODE_TURNING;
      end
      lfs_pkg::MODE_SHARP: begin
        priority if (ge_leave)      nxt = lfs_pkg::MODE_TURNING;
        else if (le_return)         nxt = lfs_pkg::MODE_STRAIGHT;
        else                        nxt = lfs_pkg::MODE_SHARP;
      end
      default: nxt = lfs_pkg::MODE_STOPPED;
    endcase
  end

  // steer = floor(gain * err / 256)
  assign prod  = PROD_W'($signed({1'b0, cfg_i.steer_gain})) * PROD_W'(err);
  assign steer = prod >>> 8;
  assign ctr   = SUM_W'($signed({1'b0, cfg_i.base_speed, 8'b0}));
  assign ls    = ctr + SUM_W'(steer);
  assign rs    = ctr - SUM_W'(steer);
  assign ls_x  = SCL_W'(ls);
  assign rs_x  = SCL_W'(rs);
  // x * 1.25 floored: (4x + x) >>> 2
  assign ls_f  = ((ls_x <<< 2) + ls_x) >>> 2;
  assign rs_f  = ((rs_x <<< 2) + rs_x) >>> 2;
  assign cruise = $signed({1'b0, cfg_i.cruise_speed, 8'b0});

  always_comb begin
    res_o.mode        = nxt;
    res_o.led         = led_i;
    res_o.left_speed  = '0;
    res_o.right_speed = '0;
    unique case (nxt)
      lfs_pkg::MODE_IDLE: begin
        res_o.led = le_ind;
      end
      lfs_pkg::MODE_STRAIGHT: begin
        res_o.left_speed  = cruise;
        res_o.right_speed = cruise;
      end
      lfs_pkg::MODE_TURNING: begin
        res_o.left_speed  = sat(ls_x);
        res_o.right_speed = sat(rs_x);
      end
      lfs_pkg::MODE_SHARP: begin
        res_o.left_speed  = sat(rdark ? ls_f : ls_x);
        res_o.right_speed = sat(ldark ? rs_f : rs_x);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
